@@ rtl/error_diffusion_dither_assert.svh @@
// Assertion macros shared by the error diffusion dither RTL.
`ifndef ERROR_DIFFUSION_DITHER_ASSERT_SVH
`define ERROR_DIFFUSION_DITHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define EDD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("error_diffusion_dither: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define EDD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("error_diffusion_dither: next-cycle check failed");

`endif

@@ rtl/edd_pkg.sv @@
// Shared constants and types of the error diffusion dither.
`default_nettype none

package edd_pkg;

  localparam int MAX_WIDTH = 512;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WCNT_W    = COL_W + 1;

  localparam int PIX_W      = 8;
  localparam int LEVELS_W   = 9;
  localparam int WIDTH_W    = 10;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LEVELS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(2);

  // Effective (range-limited) configuration.
  typedef struct packed {
    logic [PIX_W-1:0]    n;       // levels - 1
    logic [WCNT_W-1:0]   width;
    logic [HEIGHT_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic add;
    logic mul;
    logic idx;
    logic div_load;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/error_diffusion_dither.sv @@
// Error diffusion dither top level: config registers, sequencer and datapath.
//
// Floyd-Steinberg dither of one 8-bit channel in raster order. Each item is
// corrected by the error shares owed to it (upper-left, above, upper-right,
// left, clamped to 0..255 after each add), quantized to levels-1 steps, and
// its error is spread back into a per-column line store and a left carry.
// Each item runs through accept, line-store read and error adds, level
// multiply, index, divider load, the bit-serial divider iterations that
// form index*255/(levels-1), and write-back; the input stalls until that
// write-back, so the next item is accepted only once the previous one is
// through. A result waits in an output register, so the next item is
// accepted while the previous one is still unread. After reset the input
// stalls while all 512 line-store columns are cleared; configuration writes
// are taken at any time and act at once.
`default_nettype none

module error_diffusion_dither (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [edd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [edd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [edd_pkg::PIX_W-1:0]      in_pixel_value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [edd_pkg::PIX_W-1:0]           out_quantized_value,
  output logic [edd_pkg::PIX_W-1:0]           out_level_index,
  output logic                                out_end_of_frame
);
  import edd_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  edd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  edd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  edd_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_pixel_value      (in_pixel_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_quantized_value (out_quantized_value),
    .out_level_index     (out_level_index),
    .out_end_of_frame    (out_end_of_frame)
  );

endmodule

`default_nettype wire

@@ rtl/edd_cfg.sv @@
// Configuration registers and their effective ranges.
`default_nettype none

module edd_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [edd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [edd_pkg::CFG_DATA_W-1:0] cfg_data,
  output edd_pkg::cfg_t                       cfg
);
  import edd_pkg::*;

  logic [LEVELS_W-1:0] levels_r;
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= LEVELS_W'(8);
      width_r  <= WIDTH_W'(400);
      height_r <= HEIGHT_W'(300);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEVELS: levels_r <= cfg_data[LEVELS_W-1:0];
        REG_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (levels_r < LEVELS_W'(2)) begin
      cfg.n = PIX_W'(1);
    end else if (levels_r > LEVELS_W'(256)) begin
      cfg.n = PIX_W'(255);
    end else begin
      cfg.n = PIX_W'(levels_r - LEVELS_W'(1));
    end

    if (width_r == '0) begin
      cfg.width = WCNT_W'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      cfg.width = WCNT_W'(MAX_WIDTH);
    end else begin
      cfg.width = WCNT_W'(width_r);
    end

    cfg.height = (height_r == '0) ? HEIGHT_W'(1) : height_r;
  end

endmodule

`default_nettype wire

@@ rtl/edd_ctrl.sv @@
// Sequencer: line-store clear, per-item steps and divider iterations.
`default_nettype none

`include "error_diffusion_dither_assert.svh"

module edd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire edd_pkg::sts_t sts,
  output edd_pkg::cmd_t      cmd
);
  import edd_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_IDX   = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        cmd.add   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_IDX;
      end
      S_IDX: begin
        cmd.idx   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `EDD_ASSERT_NXT(a_fin_hold, (state_r == S_FIN) && !sts.out_free, state_r == S_FIN)
  `EDD_ASSERT_NXT(a_div_exit, (state_r == S_DIV) && sts.div_last, state_r == S_FIN)

endmodule

`default_nettype wire

@@ rtl/edd_datapath.sv @@
// Line store, error accumulation, quantizer, serial divider and output register.
`default_nettype none

`include "error_diffusion_dither_assert.svh"

module edd_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire edd_pkg::cfg_t             cfg,
  input  wire edd_pkg::cmd_t             cmd,
  output edd_pkg::sts_t                  sts,
  input  wire logic [edd_pkg::PIX_W-1:0] in_pixel_value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [edd_pkg::PIX_W-1:0]      out_quantized_value,
  output logic [edd_pkg::PIX_W-1:0]      out_level_index,
  output logic                           out_end_of_frame
);
  import edd_pkg::*;

  typedef logic signed [6:0] share_t;

  localparam logic [3:0] W_RIGHT      = 4'd7;
  localparam logic [3:0] W_DOWN_LEFT  = 4'd3;
  localparam logic [3:0] W_DOWN       = 4'd5;
  localparam logic [3:0] W_DOWN_RIGHT = 4'd1;
  localparam int DIV_CNT_W = $clog2(PIX_W);

  function automatic logic [PIX_W-1:0] add_clamp(input logic [PIX_W-1:0] v, input share_t d);
    logic signed [9:0] t;
    t = $signed({2'b00, v}) + $signed({{3{d[6]}}, d});
    if (t < 10'sd0) begin
      return '0;
    end else if (t > 10'sd255) begin
      return 8'hFF;
    end
    return t[7:0];
  endfunction

  // e*w/16, truncated toward zero
  function automatic share_t share(input logic signed [8:0] e, input logic [3:0] w);
    logic signed [13:0] p;
    p = e * $signed({1'b0, w});
    if (p < 14'sd0) p = p + 14'sd15;
    return p[10:4];
  endfunction

  // line store
  share_t ul_mem_r [MAX_WIDTH];
  share_t ab_mem_r [MAX_WIDTH];
  share_t ur_mem_r [MAX_WIDTH];
  share_t ul_rd_r, ab_rd_r, ur_rd_r;

  logic [COL_W-1:0]    clr_addr_r;
  logic [COL_W-1:0]    col_r;
  logic [HEIGHT_W-1:0] row_r;
  share_t              left_carry_r;
  share_t              diag_r;

  logic [PIX_W-1:0]     pix_r;
  logic [PIX_W-1:0]     v_r;
  logic [15:0]          prod_r;
  logic [PIX_W-1:0]     idx_r;
  logic [PIX_W-1:0]     rem_r;
  logic [PIX_W-1:0]     low_r;
  logic [PIX_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic                out_valid_r;
  logic [PIX_W-1:0]    out_q_r;
  logic [PIX_W-1:0]    out_idx_r;
  logic                out_eof_r;

  logic has_up, has_left, last_col, last_row;
  logic [PIX_W-1:0] v_sum;
  logic [15:0]      m_div;
  logic [16:0]      idx_sum;
  logic [15:0]      dividend;
  logic [PIX_W:0]   div_trial;
  logic             div_ge;
  logic signed [8:0] err;
  share_t s_right, s_dl, s_down, s_dr;

  logic             ul_we, ab_we, ur_we;
  logic [COL_W-1:0] ul_addr, ur_addr;
  share_t           ul_wd, ab_wd, ur_wd;

  assign has_up   = (row_r != '0);
  assign has_left = (col_r != '0);
  assign last_col = (WCNT_W'(col_r) + WCNT_W'(1)) >= cfg.width;
  assign last_row = (17'(row_r) + 17'd1) >= 17'(cfg.height);

  // shares owed: upper-left, above, upper-right, then left
  always_comb begin
    v_sum = pix_r;
    if (has_up) begin
      if (has_left) v_sum = add_clamp(v_sum, ul_rd_r);
      v_sum = add_clamp(v_sum, ab_rd_r);
      if (!last_col) v_sum = add_clamp(v_sum, ur_rd_r);
    end
    if (has_left) v_sum = add_clamp(v_sum, left_carry_r);
  end

  // (2*p + 255) / 510 == (p + 127) / 255, exact for the product range here
  assign m_div    = prod_r + 16'd127;
  assign idx_sum  = 17'(m_div) + 17'(m_div >> 8) + 17'd1;
  assign dividend = 16'({idx_r, 8'h00}) - 16'(idx_r);

  // restoring divider by n, one quotient bit a cycle; rem_r stays below n
  assign div_trial = {rem_r, low_r[PIX_W-1]};
  assign div_ge    = div_trial >= {1'b0, cfg.n};

  assign err     = $signed({1'b0, v_r}) - $signed({1'b0, quo_r});
  assign s_right = share(err, W_RIGHT);
  assign s_dl    = share(err, W_DOWN_LEFT);
  assign s_down  = share(err, W_DOWN);
  assign s_dr    = share(err, W_DOWN_RIGHT);

  always_comb begin
    ul_we   = cmd.clear | cmd.finish;
    ab_we   = cmd.clear | cmd.finish;
    ur_we   = cmd.clear | (cmd.finish & has_left);
    ul_addr = cmd.clear ? clr_addr_r : col_r;
    ur_addr = cmd.clear ? clr_addr_r : (col_r - COL_W'(1));
    ul_wd   = (cmd.clear || !has_left) ? share_t'(0) : diag_r;
    ab_wd   = cmd.clear ? share_t'(0) : s_down;
    ur_wd   = cmd.clear ? share_t'(0) : s_dl;
  end

  always_ff @(posedge clk) begin
    if (ul_we) ul_mem_r[ul_addr] <= ul_wd;
    if (cmd.accept) ul_rd_r <= ul_mem_r[col_r];
  end

  always_ff @(posedge clk) begin
    if (ab_we) ab_mem_r[ul_addr] <= ab_wd;
    if (cmd.accept) ab_rd_r <= ab_mem_r[col_r];
  end

  always_ff @(posedge clk) begin
    if (ur_we) ur_mem_r[ur_addr] <= ur_wd;
    if (cmd.accept) ur_rd_r <= ur_mem_r[col_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r   <= '0;
      col_r        <= '0;
      row_r        <= '0;
      left_carry_r <= '0;
      diag_r       <= '0;
      out_valid_r  <= 1'b0;
      div_cnt_r    <= '0;
    end else begin
      if (cmd.clear) clr_addr_r <= clr_addr_r + COL_W'(1);
      if (cmd.div_load) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      if (cmd.finish) begin
        left_carry_r <= last_col ? share_t'(0) : s_right;
        diag_r       <= last_col ? share_t'(0) : s_dr;
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : (row_r + HEIGHT_W'(1));
        end else begin
          col_r <= col_r + COL_W'(1);
        end
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) pix_r <= in_pixel_value;
    if (cmd.add) v_r <= v_sum;
    if (cmd.mul) prod_r <= 16'(v_r) * 16'(cfg.n);
    if (cmd.idx) idx_r <= idx_sum[15:8];
    if (cmd.div_load) begin
      rem_r <= dividend[15:8];
      low_r <= dividend[7:0];
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? PIX_W'(div_trial - {1'b0, cfg.n}) : div_trial[PIX_W-1:0];
      low_r <= {low_r[PIX_W-2:0], 1'b0};
      quo_r <= {quo_r[PIX_W-2:0], div_ge};
    end
    if (cmd.finish) begin
      out_q_r   <= quo_r;
      out_idx_r <= idx_r;
      out_eof_r <= last_col & last_row;
    end
  end

  assign sts.clear_last = (clr_addr_r == COL_W'(MAX_WIDTH - 1));
  assign sts.div_last   = (div_cnt_r == DIV_CNT_W'(PIX_W - 1));
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid           = out_valid_r;
  assign out_quantized_value = out_q_r;
  assign out_level_index     = out_idx_r;
  assign out_end_of_frame    = out_eof_r;

  `EDD_ASSERT_IMP(a_idx_range, out_valid_r, out_idx_r <= cfg.n)
  `EDD_ASSERT_IMP(a_rem_bound, cmd.div_step, rem_r < cfg.n)
  `EDD_ASSERT_NXT(a_row_end_carry, cmd.finish && last_col, (left_carry_r == '0) && (diag_r == '0))

endmodule

`default_nettype wire
